// ===== rtl/mm3h_pkg.sv =====
package mm3h_pkg;

	// Mixing and finalization constants
	localparam logic [31:0] MIX_C1 = 32'hcc9e2d51;
	localparam logic [31:0] MIX_C2 = 32'h1b873593;
	localparam logic [31:0] MIX_N  = 32'he6546b64;
	localparam logic [31:0] FIN_M1 = 32'h85ebca6b;
	localparam logic [31:0] FIN_M2 = 32'hc2b2ae35;

	localparam logic [2:0] WORD_BYTES = 3'd4;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_HUPD,
		ST_FIN1,
		ST_FIN2,
		ST_FIN3
	} state_t;

	// Datapath commands, one step each
	typedef struct packed {
		logic load;
		logic new_msg;
		logic mul1;
		logic mul2;
		logic hupd;
		logic fin1;
		logic fin2;
		logic fin3;
	} dp_cmd_t;

	// Datapath status
	typedef struct packed {
		logic last;
	} dp_sts_t;

endpackage

// ===== rtl/murmur3_32_stream_hash.sv =====
// Channel   Handshake                Payload
// seed      seed_valid/seed_ready    seed[31:0]
// input     in_valid/in_ready        chunk_data[31:0], byte_count[2:0], last
// output    out_valid/out_ready      hash_value[31:0]
//
// A word passes through capture, two scrambler multiplies and a hash update.
// A last word then passes through the finalizer, which shares the 32x32 multiply
// register with the scrambler. The next transaction is taken while a hash waits.
// A finished hash stalls in finalization only while the result register is full.
// arst_n clears control, the seed and the running state; seed writes are always taken.
module murmur3_32_stream_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        seed_valid,
	output logic        seed_ready,
	input  logic [31:0] seed,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] chunk_data,
	input  logic [2:0]  byte_count,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] hash_value
);

	mm3h_pkg::dp_cmd_t cmd;
	mm3h_pkg::dp_sts_t sts;

	assign seed_ready = 1'b1;

	mm3h_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mm3h_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.seed_wr    (seed_valid && seed_ready),
		.seed       (seed),
		.chunk_data (chunk_data),
		.byte_count (byte_count),
		.last       (last),
		.hash_value (hash_value)
	);

endmodule

// ===== rtl/mm3h_datapath.sv =====
module mm3h_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  mm3h_pkg::dp_cmd_t   cmd,
	output mm3h_pkg::dp_sts_t   sts,
	input  logic                seed_wr,
	input  logic [31:0]         seed,
	input  logic [31:0]         chunk_data,
	input  logic [2:0]          byte_count,
	input  logic                last,
	output logic [31:0]         hash_value
);

	localparam logic [2:0] WORD_BYTES_L = mm3h_pkg::WORD_BYTES;

	logic [31:0] seed_q;
	logic [31:0] k_q;
	logic [31:0] h_q;
	logic [31:0] total_q;
	logic        full_q;
	logic        last_q;
	logic [31:0] out_q;

	logic [2:0]  eff_count;
	logic [31:0] byte_mask;
	logic [31:0] h_base;
	logic [31:0] h_mix;
	logic [31:0] h_rot;
	logic [31:0] k_rot;
	logic [31:0] fin_x;

	// Bytes taken from this item: four unless a short last word
	always_comb begin
		if (!last || (byte_count > WORD_BYTES_L))
			eff_count = WORD_BYTES_L;
		else
			eff_count = byte_count;
	end

	// Keep only the valid tail bytes
	always_comb begin
		case (eff_count)
			3'd0:    byte_mask = 32'h0000_0000;
			3'd1:    byte_mask = 32'h0000_00ff;
			3'd2:    byte_mask = 32'h0000_ffff;
			3'd3:    byte_mask = 32'h00ff_ffff;
			default: byte_mask = 32'hffff_ffff;
		endcase
	end

	// Seed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (seed_wr) begin
			seed_q <= seed;
		end
	end

	// Hash and byte total, reloaded at message start
	assign h_base = cmd.new_msg ? seed_q : h_q;
	assign h_mix  = h_q ^ k_q;
	assign h_rot  = {h_mix[18:0], h_mix[31:19]};
	assign k_rot  = {k_q[16:0], k_q[31:17]};
	assign fin_x  = (h_q ^ total_q) ^ ((h_q ^ total_q) >> 16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q     <= '0;
			total_q <= '0;
		end else if (cmd.load) begin
			h_q     <= h_base;
			total_q <= (cmd.new_msg ? 32'd0 : total_q) + {29'd0, eff_count};
		end else if (cmd.hupd) begin
			if (full_q)
				h_q <= {h_rot[29:0], 2'b00} + h_rot + mm3h_pkg::MIX_N;
			else
				h_q <= h_mix;
		end
	end

	// Word scrambler and finalizer share one multiplier register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			k_q    <= chunk_data & byte_mask;
			full_q <= (eff_count == WORD_BYTES_L);
			last_q <= last;
		end else if (cmd.mul1) begin
			k_q <= k_q * mm3h_pkg::MIX_C1;
		end else if (cmd.mul2) begin
			k_q <= k_rot * mm3h_pkg::MIX_C2;
		end else if (cmd.fin1) begin
			k_q <= fin_x * mm3h_pkg::FIN_M1;
		end else if (cmd.fin2) begin
			k_q <= (k_q ^ (k_q >> 13)) * mm3h_pkg::FIN_M2;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.fin3) begin
			out_q <= k_q ^ (k_q >> 16);
		end
	end

	assign sts.last   = last_q;
	assign hash_value = out_q;

endmodule

// ===== rtl/mm3h_ctrl.sv =====
module mm3h_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  mm3h_pkg::dp_sts_t   sts,
	output mm3h_pkg::dp_cmd_t   cmd
);

	mm3h_pkg::state_t state_q;
	mm3h_pkg::state_t state_d;
	logic             msg_start_q;
	logic             out_valid_q;
	logic             out_load;

	// Result register is free, or being drained this cycle
	assign out_load = (state_q == mm3h_pkg::ST_FIN3) && (!out_valid_q || out_ready);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mm3h_pkg::ST_IDLE: begin
				if (in_valid)
					state_d = mm3h_pkg::ST_MUL1;
			end
			mm3h_pkg::ST_MUL1: state_d = mm3h_pkg::ST_MUL2;
			mm3h_pkg::ST_MUL2: state_d = mm3h_pkg::ST_HUPD;
			mm3h_pkg::ST_HUPD: begin
				state_d = sts.last ? mm3h_pkg::ST_FIN1 : mm3h_pkg::ST_IDLE;
			end
			mm3h_pkg::ST_FIN1: state_d = mm3h_pkg::ST_FIN2;
			mm3h_pkg::ST_FIN2: state_d = mm3h_pkg::ST_FIN3;
			mm3h_pkg::ST_FIN3: begin
				if (out_load)
					state_d = mm3h_pkg::ST_IDLE;
			end
			default: state_d = mm3h_pkg::ST_IDLE;
		endcase
	end

	// Outputs and datapath commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			mm3h_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load    = in_valid;
				cmd.new_msg = msg_start_q;
			end
			mm3h_pkg::ST_MUL1: cmd.mul1 = 1'b1;
			mm3h_pkg::ST_MUL2: cmd.mul2 = 1'b1;
			mm3h_pkg::ST_HUPD: cmd.hupd = 1'b1;
			mm3h_pkg::ST_FIN1: cmd.fin1 = 1'b1;
			mm3h_pkg::ST_FIN2: cmd.fin2 = 1'b1;
			mm3h_pkg::ST_FIN3: cmd.fin3 = out_load;
			default: cmd = '0;
		endcase
	end

	// State, message start flag and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mm3h_pkg::ST_IDLE;
			msg_start_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load)
				msg_start_q <= 1'b0;
			else if (cmd.hupd && sts.last)
				msg_start_q <= 1'b1;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// An accepted transaction always starts the scrambler
	a_accept_mul1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == mm3h_pkg::ST_MUL1))
		else $error("accepted transaction did not start mixing");

	// A finished hash waits while the result register is still full
	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mm3h_pkg::ST_FIN3 && out_valid_q && !out_ready)
		|=> (state_q == mm3h_pkg::ST_FIN3))
		else $error("result overwritten while pending");

	// Body word returns to idle, last word goes to finalization
	a_body_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mm3h_pkg::ST_HUPD && !sts.last) |=> (state_q == mm3h_pkg::ST_IDLE))
		else $error("body word did not return to idle");

	// End of a message arms the seed reload
	a_msg_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mm3h_pkg::ST_HUPD && sts.last) |=> msg_start_q)
		else $error("message start not rearmed");

endmodule

// ===== sim/murmur3_32_hash_checker.sv =====
`timescale 1ns / 1ps

// Watches the seed, chunk and hash channels, predicts each message hash and
// compares it with what the block delivers.
module murmur3_32_hash_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        seed_valid,
	input  logic        seed_ready,
	input  logic [31:0] seed,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] chunk_data,
	input  logic [2:0]  byte_count,
	input  logic        last,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] hash_value,
	output int          fail_count,
	output int          pending
);

	localparam int REPORT_LIMIT = 10;

	logic [31:0] seed_shadow;
	logic [31:0] hash_acc;
	logic [31:0] byte_sum;
	logic        at_msg_start;
	logic [31:0] expected_hash[$];

	function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	// Body/tail word scramble
	function automatic logic [31:0] scramble_word(input logic [31:0] k);
		logic [31:0] t;
		t = k * mm3h_pkg::MIX_C1;
		t = rotl(t, 15);
		t = t * mm3h_pkg::MIX_C2;
		return t;
	endfunction

	// Final avalanche
	function automatic logic [31:0] avalanche(input logic [31:0] h);
		logic [31:0] t;
		t = h ^ (h >> 16);
		t = t * mm3h_pkg::FIN_M1;
		t = t ^ (t >> 13);
		t = t * mm3h_pkg::FIN_M2;
		t = t ^ (t >> 16);
		return t;
	endfunction

	// Compare first, then fold in new transactions
	always @(posedge clk or negedge arst_n) begin : predict_and_compare
		logic [31:0] want;
		logic [2:0]  nbytes;
		if (!arst_n) begin
			seed_shadow = '0;
			hash_acc = '0;
			byte_sum = '0;
			at_msg_start = 1'b1;
			expected_hash.delete();
			pending = 0;
		end else begin
			// hash channel
			if (out_valid && out_ready) begin
				if (expected_hash.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("%0t: unexpected hash %08h", $realtime, hash_value);
				end else begin
					want = expected_hash.pop_front();
					if (want !== hash_value) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT)
							$display("%0t: hash mismatch, expected %08h got %08h",
								$realtime, want, hash_value);
					end
				end
			end

			// seed register
			if (seed_valid && seed_ready)
				seed_shadow = seed;

			// chunk channel
			if (in_valid && in_ready) begin
				if (at_msg_start) begin
					hash_acc = seed_shadow;
					byte_sum = '0;
					at_msg_start = 1'b0;
				end
				// non-last chunks and oversize counts take a full word
				nbytes = (!last || byte_count > mm3h_pkg::WORD_BYTES) ?
					mm3h_pkg::WORD_BYTES : byte_count;
				if (nbytes == mm3h_pkg::WORD_BYTES) begin
					hash_acc = hash_acc ^ scramble_word(chunk_data);
					hash_acc = rotl(hash_acc, 13);
					hash_acc = hash_acc * 32'd5 + mm3h_pkg::MIX_N;
				end else if (nbytes != 3'd0) begin
					// tail: bytes above the count are dropped
					hash_acc = hash_acc ^
						scramble_word(chunk_data & ~(32'hffffffff << (8 * nbytes)));
				end
				byte_sum = byte_sum + {29'd0, nbytes};
				if (last) begin
					expected_hash.push_back(avalanche(hash_acc ^ byte_sum));
					at_msg_start = 1'b1;
				end
			end
			pending = expected_hash.size();
		end
	end

endmodule

// ===== sim/murmur3_32_stream_hash_tb.sv =====
`timescale 1ns / 1ps

module murmur3_32_stream_hash_tb;

	localparam int ITEM_TARGET    = 550;
	localparam int PHASE_ITEMS    = 80;
	localparam int HOLD_CYCLES    = 80;
	localparam int DRAIN_CYCLES   = 12;
	localparam int WATCHDOG_LIMIT = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        seed_valid = 1'b0;
	logic        seed_ready;
	logic [31:0] seed = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] chunk_data = '0;
	logic [2:0]  byte_count = '0;
	logic        last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] hash_value;

	int fail_count;
	int pending;
	int chunks_sent = 0;
	int quiet_cycles = 0;
	int phase = 0;
	int phase_start;
	bit calm = 1'b0;
	bit hold_req = 1'b0;

	murmur3_32_stream_hash i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed_valid (seed_valid),
		.seed_ready (seed_ready),
		.seed       (seed),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.chunk_data (chunk_data),
		.byte_count (byte_count),
		.last       (last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hash_value (hash_value)
	);

	murmur3_32_hash_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed_valid (seed_valid),
		.seed_ready (seed_ready),
		.seed       (seed),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.chunk_data (chunk_data),
		.byte_count (byte_count),
		.last       (last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hash_value (hash_value),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Hash receiver: random back-pressure, plus one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			out_ready = calm || ($urandom_range(99) >= 12);
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) ||
			(seed_valid && seed_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// One chunk transaction, with an optional gap in front
	task automatic push_chunk(input logic [31:0] d, input logic [2:0] cnt, input logic l);
		@(negedge clk);
		if (!calm && $urandom_range(99) < 12) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		chunk_data = d;
		byte_count = cnt;
		last = l;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		chunks_sent++;
	endtask

	task automatic send_message(input int n_words);
		for (int i = 0; i < n_words - 1; i++)
			push_chunk($urandom, 3'($urandom_range(0, 7)), 1'b0);
		push_chunk($urandom, 3'($urandom_range(0, 7)), 1'b1);
	endtask

	// Stop offering chunks and let every hash come out
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_seed(input logic [31:0] v);
		@(negedge clk);
		seed = v;
		seed_valid = 1'b1;
		do @(posedge clk); while (!seed_ready);
		@(negedge clk);
		seed_valid = 1'b0;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset seed, empty message, full word, tails, oversize counts
		push_chunk(32'h00000000, 3'd0, 1'b1);
		push_chunk(32'h00000000, 3'd4, 1'b1);
		push_chunk(32'hffffffff, 3'd1, 1'b1);
		push_chunk(32'hffffffff, 3'd2, 1'b1);
		push_chunk(32'hffffffff, 3'd3, 1'b1);
		push_chunk(32'h12345678, 3'd5, 1'b1);
		push_chunk(32'h12345678, 3'd6, 1'b1);
		push_chunk(32'h12345678, 3'd7, 1'b1);
		// counts on non-last chunks are ignored
		push_chunk(32'hffffffff, 3'd0, 1'b0);
		push_chunk(32'h80000000, 3'd7, 1'b0);
		push_chunk(32'h00000001, 3'd3, 1'b1);
		// full word followed by an empty last chunk
		push_chunk(32'hdeadbeef, 3'd4, 1'b0);
		push_chunk(32'h00000000, 3'd0, 1'b1);
		drain();
		write_seed(32'hffffffff);
		push_chunk(32'hffffffff, 3'd4, 1'b1);
		push_chunk(32'h00000000, 3'd0, 1'b1);
		push_chunk(32'hffffffff, 3'd4, 1'b0);
		push_chunk(32'hffff00ff, 3'd2, 1'b1);

		// random phases, a new seed between each
		while (chunks_sent < ITEM_TARGET) begin
			drain();
			case (phase % 4)
				0: write_seed(32'h00000000);
				1: write_seed(32'hffffffff);
				default: write_seed($urandom);
			endcase
			calm = (phase == 2);
			// back up the block behind a stalled receiver
			if (phase == 1) begin
				hold_req = 1'b1;
				repeat (8) send_message($urandom_range(1, 2));
			end
			phase_start = chunks_sent;
			while ((chunks_sent - phase_start < PHASE_ITEMS) &&
				(chunks_sent < ITEM_TARGET)) begin
				if ($urandom_range(99) < 85)
					send_message($urandom_range(1, 5));
				else
					send_message($urandom_range(6, 12));
			end
			phase++;
		end
		calm = 1'b0;
		drain();

		@(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
